@@ rtl/sida_pkg.sv @@
// Package for the signed integer to decimal ASCII converter.
// Holds character codes and digit widths shared by the converter modules.
package sida_pkg;

  localparam int DIGIT_W   = 4;
  localparam int CODE_W    = 6;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CODE_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CODE_W-1:0] CHAR_MINUS = 6'd45;

endpackage

@@ rtl/sida_dabble.sv @@
// Iterative binary to BCD unit: one shift-add-3 step per cycle.
// Depends on sida_pkg for the digit width.
module sida_dabble import sida_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int NDIG       = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [DATA_WIDTH-1:0]     mag,
  output logic                      busy,
  output logic                      done,
  output logic [NDIG*DIGIT_W-1:0]   bcd
);

  localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
  localparam int BW = NDIG * DIGIT_W;

  logic [BW-1:0]         bcd_r;
  logic [DATA_WIDTH-1:0] sh_r;
  logic [CW-1:0]         cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [BW-1:0]         corr;

  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        corr[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        corr[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        bcd_r  <= '0;
        sh_r   <= mag;
      end else if (busy_r) begin
        bcd_r <= {corr[BW-2:0], sh_r[DATA_WIDTH-1]};
        sh_r  <= {sh_r[DATA_WIDTH-2:0], 1'b0};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DATA_WIDTH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

@@ rtl/signed_int_to_decimal_ascii.sv @@
// Top level: signed integer in, decimal ASCII characters out, one beat each.
// Depends on sida_pkg and sida_dabble.
// Sequence: the shift-add-3 unit converts the magnitude, then up to NDIG-1
// leading zeros are stripped and the sign is picked, then one character per
// cycle while out_tready allows. One value is converted at a time, set by the
// single shift-add-3 unit; in_tready is low until the last character is loaded.
// Reset: synchronous active-low rst_n clears the sequencer and output valid.
module signed_int_to_decimal_ascii import sida_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // bits low to high: value
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // bits low to high: char_code, zero fill
  output logic [OUT_TDATA_W-1:0]             out_tdata,
  output logic                               out_tlast
);

  localparam int NDIG = (DATA_WIDTH * 30103) / 100000 + 1;
  localparam int BW   = NDIG * DIGIT_W;
  localparam int NCW  = $clog2(NDIG + 1);

  typedef enum logic [2:0] {S_IDLE, S_CONV, S_TRIM, S_SIGN, S_EMIT} state_t;

  state_t                state_r;
  logic                  neg_r;
  logic [BW-1:0]         bcd_r;
  logic [NCW-1:0]        cnt_r;
  logic                  out_valid_r;
  logic [CODE_W-1:0]     code_r;
  logic                  last_r;

  logic [DATA_WIDTH-1:0] val;
  logic [DATA_WIDTH-1:0] mag;
  logic                  start;
  logic                  dab_busy;
  logic                  dab_done;
  logic [BW-1:0]         dab_bcd;
  logic                  out_free;
  logic                  char_load;
  logic [DIGIT_W-1:0]    top_digit;

  assign val       = in_tdata[DATA_WIDTH-1:0];
  assign mag       = val[DATA_WIDTH-1] ? (~val + DATA_WIDTH'(1)) : val;
  assign in_tready = (state_r == S_IDLE);
  assign start     = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign char_load = out_free && (state_r == S_SIGN || state_r == S_EMIT);
  assign top_digit = bcd_r[BW-1 -: DIGIT_W];

  sida_dabble #(
    .DATA_WIDTH (DATA_WIDTH),
    .NDIG       (NDIG)
  ) u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mag   (mag),
    .busy  (dab_busy),
    .done  (dab_done),
    .bcd   (dab_bcd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (char_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            neg_r   <= val[DATA_WIDTH-1];
            state_r <= S_CONV;
          end
        end
        S_CONV: begin
          if (dab_done) begin
            bcd_r   <= dab_bcd;
            cnt_r   <= NCW'(NDIG);
            state_r <= S_TRIM;
          end
        end
        S_TRIM: begin
          if (top_digit == '0 && cnt_r != NCW'(1)) begin
            bcd_r <= {bcd_r[BW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            cnt_r <= cnt_r - NCW'(1);
          end else begin
            state_r <= neg_r ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            code_r      <= CHAR_MINUS;
            last_r      <= 1'b0;
            state_r     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            code_r      <= CHAR_ZERO + CODE_W'(top_digit);
            last_r      <= (cnt_r == NCW'(1));
            bcd_r       <= {bcd_r[BW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            cnt_r       <= cnt_r - NCW'(1);
            if (cnt_r == NCW'(1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-CODE_W){1'b0}}, code_r};
  assign out_tlast  = last_r;

  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> state_r == S_CONV)
    else $error("accepted value did not enter conversion");

  a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    dab_done |-> state_r == S_CONV)
    else $error("conversion done outside conversion state");

  a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !dab_busy)
    else $error("ready while conversion unit busy");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid_r && last_r && code_r == CHAR_MINUS))
    else $error("minus sign flagged as last character");

endmodule
